// ===== rtl/segint_pkg.sv =====
// ----------------------------------------------------------------------------
// segint_pkg: shared types and constants for the segment intersection test
// Pipeline depth and the small flag groups that travel down the pipeline.
// ----------------------------------------------------------------------------
package segint_pkg;

  // Register levels from the accepting edge to the edge that takes the result
  localparam int LATENCY = 7;

  // Sign of one cross product
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // Outcome of the orientation rule, carried until the final select
  typedef struct packed {
    logic hit;       // orientation alone says the segments meet
    logic need_len;  // both orientation products are zero: use the length test
  } rule_t;

endpackage

// ===== rtl/segment_intersection_test_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_core: 2D segment pair intersection test
// Exact integer test of two segments given by signed endpoint coordinates.
// ----------------------------------------------------------------------------
// A segment pair is taken on every clock edge at which start is high; busy is
// held low, so a new item can follow in every cycle. The result appears on
// out_intersects with out_valid high for exactly one cycle, and must be picked
// up at the edge that ends that cycle, the seventh after the accepting one.
// The pipeline holds the input register, coordinate differences, cross
// products and squares, signs and the length difference d, split partial
// products for d*d and a*b, recombination, and the final compare. Touching,
// crossing and overlapping collinear segments all report 1.
// ----------------------------------------------------------------------------
module segment_intersection_test_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  output logic                         out_valid,
  output logic                         out_intersects
);
  import segint_pkg::*;

  localparam int N    = COORD_BITS;
  localparam int DW   = N + 1;        // coordinate difference
  localparam int SW   = N + 2;        // doubled midpoint difference
  localparam int PW   = 2 * N + 2;    // product of two differences
  localparam int CW   = 2 * N + 3;    // cross product
  localparam int LQW  = 2 * N;        // square of a direction component
  localparam int LW   = 2 * N + 1;    // squared length of a segment
  localparam int SQW  = 2 * N + 3;    // square of a midpoint component
  localparam int SSW  = 2 * N + 4;    // squared midpoint distance
  localparam int DSW  = 2 * N + 5;    // signed d = s - a - b
  localparam int DMW  = DSW - 1;      // magnitude of d when positive
  localparam int HD   = DMW / 2;      // split point of d
  localparam int LPW  = LW + 1;       // squared length padded to even width
  localparam int HL   = LPW / 2;      // split point of a and b
  localparam int QW   = 2 * DMW;      // width of d*d and 4ab

  logic accept;

  // Never stall the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: capture the item
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [N-1:0]  ax1_r, ay1_r, ax2_r, ay2_r, bx1_r, by1_r, bx2_r, by2_r;

  always_ff @(posedge clk) begin
    ax1_r <= in_a_start_x;
    ay1_r <= in_a_start_y;
    ax2_r <= in_a_end_x;
    ay2_r <= in_a_end_y;
    bx1_r <= in_b_start_x;
    by1_r <= in_b_start_y;
    bx2_r <= in_b_end_x;
    by2_r <= in_b_end_y;
  end

  // --------------------------------------------------------------------------
  // Stage 2: directions, endpoints relative to each start, midpoint offset
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dax_nxt, day_nxt, dbx_nxt, dby_nxt;
  logic signed [DW-1:0] ra1x_nxt, ra1y_nxt, ra2x_nxt, ra2y_nxt;
  logic signed [DW-1:0] rb1x_nxt, rb1y_nxt, rb2x_nxt, rb2y_nxt;
  logic signed [SW-1:0] sx_nxt, sy_nxt;

  always_comb begin
    dax_nxt  = DW'(ax2_r) - DW'(ax1_r);
    day_nxt  = DW'(ay2_r) - DW'(ay1_r);
    dbx_nxt  = DW'(bx2_r) - DW'(bx1_r);
    dby_nxt  = DW'(by2_r) - DW'(by1_r);
    // B endpoints seen from A's start
    ra1x_nxt = DW'(bx1_r) - DW'(ax1_r);
    ra1y_nxt = DW'(by1_r) - DW'(ay1_r);
    ra2x_nxt = DW'(bx2_r) - DW'(ax1_r);
    ra2y_nxt = DW'(by2_r) - DW'(ay1_r);
    // A endpoints seen from B's start
    rb1x_nxt = DW'(ax1_r) - DW'(bx1_r);
    rb1y_nxt = DW'(ay1_r) - DW'(by1_r);
    rb2x_nxt = DW'(ax2_r) - DW'(bx1_r);
    rb2y_nxt = DW'(ay2_r) - DW'(by1_r);
    sx_nxt   = (SW'(ax1_r) + SW'(ax2_r)) - (SW'(bx1_r) + SW'(bx2_r));
    sy_nxt   = (SW'(ay1_r) + SW'(ay2_r)) - (SW'(by1_r) + SW'(by2_r));
  end

  logic                 v2_r;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r;
  logic signed [DW-1:0] ra1x_r, ra1y_r, ra2x_r, ra2y_r;
  logic signed [DW-1:0] rb1x_r, rb1y_r, rb2x_r, rb2y_r;
  logic signed [SW-1:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    dax_r  <= dax_nxt;
    day_r  <= day_nxt;
    dbx_r  <= dbx_nxt;
    dby_r  <= dby_nxt;
    ra1x_r <= ra1x_nxt;
    ra1y_r <= ra1y_nxt;
    ra2x_r <= ra2x_nxt;
    ra2y_r <= ra2y_nxt;
    rb1x_r <= rb1x_nxt;
    rb1y_r <= rb1y_nxt;
    rb2x_r <= rb2x_nxt;
    rb2y_r <= rb2y_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross product terms and squares
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]   ma1p_nxt, ma1q_nxt, ma2p_nxt, ma2q_nxt;
  logic signed [PW-1:0]   mb1p_nxt, mb1q_nxt, mb2p_nxt, mb2q_nxt;
  logic signed [PW-1:0]   qax_nxt, qay_nxt, qbx_nxt, qby_nxt;
  logic signed [2*SW-1:0] qsx_nxt, qsy_nxt;

  always_comb begin
    ma1p_nxt = dax_r * ra1y_r;
    ma1q_nxt = day_r * ra1x_r;
    ma2p_nxt = dax_r * ra2y_r;
    ma2q_nxt = day_r * ra2x_r;
    mb1p_nxt = dbx_r * rb1y_r;
    mb1q_nxt = dby_r * rb1x_r;
    mb2p_nxt = dbx_r * rb2y_r;
    mb2q_nxt = dby_r * rb2x_r;
    qax_nxt  = dax_r * dax_r;
    qay_nxt  = day_r * day_r;
    qbx_nxt  = dbx_r * dbx_r;
    qby_nxt  = dby_r * dby_r;
    qsx_nxt  = sx_r * sx_r;
    qsy_nxt  = sy_r * sy_r;
  end

  logic                 v3_r;
  logic signed [PW-1:0] ma1p_r, ma1q_r, ma2p_r, ma2q_r;
  logic signed [PW-1:0] mb1p_r, mb1q_r, mb2p_r, mb2q_r;
  logic [LQW-1:0]       qax_r, qay_r, qbx_r, qby_r;
  logic [SQW-1:0]       qsx_r, qsy_r;

  // Squares are non-negative: keep only the magnitude bits
  always_ff @(posedge clk) begin
    ma1p_r <= ma1p_nxt;
    ma1q_r <= ma1q_nxt;
    ma2p_r <= ma2p_nxt;
    ma2q_r <= ma2q_nxt;
    mb1p_r <= mb1p_nxt;
    mb1q_r <= mb1q_nxt;
    mb2p_r <= mb2p_nxt;
    mb2q_r <= mb2q_nxt;
    qax_r  <= qax_nxt[LQW-1:0];
    qay_r  <= qay_nxt[LQW-1:0];
    qbx_r  <= qbx_nxt[LQW-1:0];
    qby_r  <= qby_nxt[LQW-1:0];
    qsx_r  <= qsx_nxt[SQW-1:0];
    qsy_r  <= qsy_nxt[SQW-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 4: cross signs, orientation rule, squared lengths and d
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]  ca1, ca2, cb1, cb2;
  sgn_t                  sa1, sa2, sb1, sb2;
  logic                  zero_a, neg_a, pos_a, zero_b, neg_b, pos_b;
  rule_t                 rule_nxt;
  logic [SSW-1:0]        s_len;
  logic [LW-1:0]         a_len_nxt, b_len_nxt;
  logic signed [DSW-1:0] d_full;
  logic                  dpos_nxt;

  always_comb begin
    ca1 = CW'(ma1p_r) - CW'(ma1q_r);
    ca2 = CW'(ma2p_r) - CW'(ma2q_r);
    cb1 = CW'(mb1p_r) - CW'(mb1q_r);
    cb2 = CW'(mb2p_r) - CW'(mb2q_r);
    sa1 = '{neg: ca1[CW-1], zero: (ca1 == '0)};
    sa2 = '{neg: ca2[CW-1], zero: (ca2 == '0)};
    sb1 = '{neg: cb1[CW-1], zero: (cb1 == '0)};
    sb2 = '{neg: cb2[CW-1], zero: (cb2 == '0)};

    // Sign of each product of two cross products
    zero_a = sa1.zero || sa2.zero;
    neg_a  = !zero_a && (sa1.neg ^ sa2.neg);
    pos_a  = !zero_a && !(sa1.neg ^ sa2.neg);
    zero_b = sb1.zero || sb2.zero;
    neg_b  = !zero_b && (sb1.neg ^ sb2.neg);
    pos_b  = !zero_b && !(sb1.neg ^ sb2.neg);

    // Hit when nothing is positive and something is negative
    rule_nxt.hit      = !(pos_a || pos_b) && (neg_a || neg_b);
    rule_nxt.need_len = zero_a && zero_b;

    // Collinear case: d = s - a - b
    s_len     = SSW'(qsx_r) + SSW'(qsy_r);
    a_len_nxt = LW'(qax_r) + LW'(qay_r);
    b_len_nxt = LW'(qbx_r) + LW'(qby_r);
    d_full    = $signed(DSW'(s_len)) - $signed(DSW'(a_len_nxt))
              - $signed(DSW'(b_len_nxt));
    dpos_nxt  = !d_full[DSW-1] && (d_full != '0);
  end

  logic            v4_r;
  rule_t           rule4_r;
  logic            dpos4_r;
  logic [DMW-1:0]  dmag_r;
  logic [LW-1:0]   a_len_r, b_len_r;

  always_ff @(posedge clk) begin
    rule4_r <= rule_nxt;
    dpos4_r <= dpos_nxt;
    dmag_r  <= d_full[DMW-1:0];
    a_len_r <= a_len_nxt;
    b_len_r <= b_len_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 5: split partial products of d*d and a*b
  // --------------------------------------------------------------------------
  logic [DMW-HD-1:0] d_hi;
  logic [HD-1:0]     d_lo;
  logic [LPW-1:0]    a_pad, b_pad;
  logic [HL-1:0]     a_hi, a_lo, b_hi, b_lo;
  logic [DMW-1:0]    dhh_nxt, dhl_nxt, dll_nxt;
  logic [LPW-1:0]    phh_nxt, phl_nxt, plh_nxt, pll_nxt;

  always_comb begin
    d_hi    = dmag_r[DMW-1:HD];
    d_lo    = dmag_r[HD-1:0];
    a_pad   = LPW'(a_len_r);
    b_pad   = LPW'(b_len_r);
    a_hi    = a_pad[LPW-1:HL];
    a_lo    = a_pad[HL-1:0];
    b_hi    = b_pad[LPW-1:HL];
    b_lo    = b_pad[HL-1:0];
    dhh_nxt = DMW'(d_hi) * DMW'(d_hi);
    dhl_nxt = DMW'(d_hi) * DMW'(d_lo);
    dll_nxt = DMW'(d_lo) * DMW'(d_lo);
    phh_nxt = LPW'(a_hi) * LPW'(b_hi);
    phl_nxt = LPW'(a_hi) * LPW'(b_lo);
    plh_nxt = LPW'(a_lo) * LPW'(b_hi);
    pll_nxt = LPW'(a_lo) * LPW'(b_lo);
  end

  logic           v5_r;
  rule_t          rule5_r;
  logic           dpos5_r;
  logic [DMW-1:0] dhh_r, dhl_r, dll_r;
  logic [LPW-1:0] phh_r, phl_r, plh_r, pll_r;

  always_ff @(posedge clk) begin
    rule5_r <= rule4_r;
    dpos5_r <= dpos4_r;
    dhh_r   <= dhh_nxt;
    dhl_r   <= dhl_nxt;
    dll_r   <= dll_nxt;
    phh_r   <= phh_nxt;
    phl_r   <= phl_nxt;
    plh_r   <= plh_nxt;
    pll_r   <= pll_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine d*d and 4ab
  // --------------------------------------------------------------------------
  logic [QW-1:0] dsq_nxt, ab_sum, q4_nxt;

  always_comb begin
    dsq_nxt = (QW'(dhh_r) << (2 * HD)) + (QW'(dhl_r) << (HD + 1)) + QW'(dll_r);
    ab_sum  = (QW'(phh_r) << (2 * HL)) + (QW'(phl_r) << HL)
            + (QW'(plh_r) << HL) + QW'(pll_r);
    q4_nxt  = ab_sum << 2;
  end

  logic          v6_r;
  rule_t         rule6_r;
  logic          dpos6_r;
  logic [QW-1:0] dsq_r, q4_r;

  always_ff @(posedge clk) begin
    rule6_r <= rule5_r;
    dpos6_r <= dpos5_r;
    dsq_r   <= dsq_nxt;
    q4_r    <= q4_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 7: final select into the output register
  // --------------------------------------------------------------------------
  logic intersects_nxt;
  logic out_valid_r, out_intersects_r;

  // Collinear segments are apart only when d > 0 and d*d > 4ab
  always_comb begin
    if (rule6_r.need_len) begin
      intersects_nxt = !(dpos6_r && (dsq_r > q4_r));
    end else begin
      intersects_nxt = rule6_r.hit;
    end
  end

  always_ff @(posedge clk) begin
    out_intersects_r <= intersects_nxt;
  end

  // Advance the valid bits; reset drops every item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_intersects_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every accepted item yields its strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted item did not produce a result on time");

  // No strobe without an item accepted the latency before
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##LATENCY !out_valid)
    else $error("result strobe without an accepted item");

  // A segment tested against itself always meets
  a_self_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_a_start_x == in_b_start_x) && (in_a_start_y == in_b_start_y)
            && (in_a_end_x == in_b_end_x) && (in_a_end_y == in_b_end_y))
    |-> ##LATENCY (out_valid && out_intersects))
    else $error("identical segments reported apart");

endmodule
